FILE: design/mfa_pkg.sv
// Package: shared widths, opcodes and divider request/answer types for the mixed fraction ALU.
`timescale 1ns / 1ps
`default_nettype none
package mfa_pkg;
	localparam int OPERAND_BITS = 16;
	localparam int IN_W = 16;
	localparam int IMP_W = 2 * OPERAND_BITS;
	localparam int MAG_W = 2 * IMP_W + 1;
	localparam int WHOLE_W = 50;
	localparam int FRAC_W = 32;
	localparam int CNT_W = $clog2(MAG_W + 1);

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	typedef logic [MAG_W-1:0] mag_t;

	// Request to and answer from the shared divider.
	typedef struct packed {
		logic go;
		mag_t num;
		mag_t den;
	} div_req_t;

	typedef struct packed {
		logic done;
		mag_t quo;
		mag_t rem;
	} div_rsp_t;
endpackage
`default_nettype wire

FILE: design/mfa_mul.sv
// Multiplier for the operand products: one 32 x 32 product, registered.
`timescale 1ns / 1ps
`default_nettype none
module mfa_mul (
	input  wire logic                       clk,
	input  wire logic [mfa_pkg::IMP_W-1:0]  x,
	input  wire logic [mfa_pkg::IMP_W-1:0]  y,
	output logic [2*mfa_pkg::IMP_W-1:0]     p
);
	import mfa_pkg::*;

	// Product register.
	always_ff @(posedge clk) begin
		p <= x * y;
	end
endmodule
`default_nettype wire

FILE: design/mfa_div.sv
// Shared restoring divider: one quotient bit per cycle while busy.
`timescale 1ns / 1ps
`default_nettype none
module mfa_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mfa_pkg::div_req_t  req,
	output mfa_pkg::div_rsp_t       rsp
);
	import mfa_pkg::*;

	logic [MAG_W-1:0] num_q, den_q, rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [MAG_W:0] trial;
	logic [MAG_W:0] shifted;

	// One shift and trial subtract per step.
	assign shifted = {rem_q, num_q[MAG_W-1]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req.go) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[MAG_W]) begin
				rem_q <= trial[MAG_W-1:0];
				num_q <= {num_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[MAG_W-1:0];
				num_q <= {num_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = num_q;
	assign rsp.rem = rem_q;
endmodule
`default_nettype wire

FILE: design/mixed_fraction_alu_top.sv
// Top level: sequencer around a shared multiplier and a shared divider.
//
// Channel  Direction  Handshake         Payload
// command  in         start & !busy     opcode, a_*, b_*
// result   out        done (one cycle)  res_negative, res_whole, res_num, res_den, error
//
// After acceptance an item forms the operands and products in the steps IMP1, IMP2,
// P1, P2, P3 and COMB. Each pass of the shared divider takes 65 steps.
// A nonzero result takes one pass per GCD remainder step, two to reduce and one for
// the whole part, then the output step. A zero result takes only the whole-part pass,
// and an error is reported from COMB without a divider pass.
// busy is high from acceptance until the cycle that done is high.
// Reset clears the sequencer; results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module mixed_fraction_alu_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    opcode,
	input  wire logic                          a_negative,
	input  wire logic [mfa_pkg::IN_W-1:0]      a_whole,
	input  wire logic [mfa_pkg::IN_W-1:0]      a_num,
	input  wire logic [mfa_pkg::IN_W-1:0]      a_den,
	input  wire logic                          b_negative,
	input  wire logic [mfa_pkg::IN_W-1:0]      b_whole,
	input  wire logic [mfa_pkg::IN_W-1:0]      b_num,
	input  wire logic [mfa_pkg::IN_W-1:0]      b_den,
	output logic                               done,
	output logic                               res_negative,
	output logic [mfa_pkg::WHOLE_W-1:0]        res_whole,
	output logic [mfa_pkg::FRAC_W-1:0]         res_num,
	output logic [mfa_pkg::FRAC_W-1:0]         res_den,
	output logic                               error
);
	import mfa_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_IMP1 = 4'd1;
	localparam logic [3:0] S_IMP2 = 4'd2;
	localparam logic [3:0] S_P1   = 4'd3;
	localparam logic [3:0] S_P2   = 4'd4;
	localparam logic [3:0] S_P3   = 4'd5;
	localparam logic [3:0] S_COMB = 4'd6;
	localparam logic [3:0] S_GCD  = 4'd7;
	localparam logic [3:0] S_RED1 = 4'd8;
	localparam logic [3:0] S_RED2 = 4'd9;
	localparam logic [3:0] S_WHL  = 4'd10;
	localparam logic [3:0] S_OUT  = 4'd11;
	localparam logic [3:0] S_WAIT = 4'd12;

	logic [3:0] state_q, ret_q;
	logic [1:0] op_q;
	logic sa_q, sb_q, neg_q;
	logic [OPERAND_BITS-1:0] aw_q, an_q, ad_q, bw_q, bn_q, bd_q;
	logic [IMP_W-1:0] n1_q, n2_q;
	logic [IMP_W-1:0] mx, my;
	logic [2*IMP_W-1:0] prod;
	mag_t x_q, y_q, den_q, mag_q, ga_q, gb_q;
	div_req_t dreq;
	div_rsp_t drsp;
	logic sy;

	mfa_mul u_mul (.clk(clk), .x(mx), .y(my), .p(prod));
	mfa_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// Multiplier operand selection by step.
	always_comb begin
		mx = '0;
		my = '0;
		case (state_q)
			S_IMP1: begin
				mx = IMP_W'(aw_q);
				my = IMP_W'(ad_q);
			end
			S_IMP2: begin
				mx = IMP_W'(bw_q);
				my = IMP_W'(bd_q);
			end
			S_P1: begin
				mx = n1_q;
				my = IMP_W'(bd_q);
			end
			S_P2: begin
				mx = n2_q;
				my = (op_q == OP_MUL) ? n1_q : IMP_W'(ad_q);
			end
			S_P3: begin
				mx = IMP_W'(ad_q);
				my = (op_q == OP_DIV) ? n2_q : IMP_W'(bd_q);
			end
			default: begin
				mx = '0;
				my = '0;
			end
		endcase
	end

	assign sy = (op_q == OP_SUB) ? !sb_q : sb_q;
	assign busy = (state_q != S_IDLE);

	// Sequencer and datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			done <= 1'b0;
			dreq.go <= 1'b0;
		end else begin
			done <= 1'b0;
			dreq.go <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_IMP1;
						op_q <= opcode;
						sa_q <= a_negative;
						sb_q <= b_negative;
						aw_q <= a_whole[OPERAND_BITS-1:0];
						an_q <= a_num[OPERAND_BITS-1:0];
						ad_q <= a_den[OPERAND_BITS-1:0];
						bw_q <= b_whole[OPERAND_BITS-1:0];
						bn_q <= b_num[OPERAND_BITS-1:0];
						bd_q <= b_den[OPERAND_BITS-1:0];
					end
				end
				S_IMP1: state_q <= S_IMP2;
				S_IMP2: begin
					n1_q <= prod[IMP_W-1:0] + IMP_W'(an_q);
					state_q <= S_P1;
				end
				S_P1: begin
					n2_q <= prod[IMP_W-1:0] + IMP_W'(bn_q);
					state_q <= S_P2;
				end
				S_P2: begin
					x_q <= MAG_W'(prod);
					state_q <= S_P3;
				end
				S_P3: begin
					y_q <= MAG_W'(prod);
					state_q <= S_COMB;
				end
				S_COMB: begin
					den_q <= MAG_W'(prod);
					if (ad_q == '0 || bd_q == '0 || (op_q == OP_DIV && n2_q == '0)) begin
						done <= 1'b1;
						error <= 1'b1;
						res_negative <= 1'b0;
						res_whole <= '0;
						res_num <= '0;
						res_den <= '0;
						state_q <= S_IDLE;
					end else begin
						if (op_q == OP_MUL || op_q == OP_DIV) begin
							mag_q <= (op_q == OP_MUL) ? y_q : x_q;
							neg_q <= sa_q ^ sb_q;
						end else if (sa_q == sy) begin
							mag_q <= x_q + y_q;
							neg_q <= sa_q;
						end else if (x_q >= y_q) begin
							mag_q <= x_q - y_q;
							neg_q <= sa_q;
						end else begin
							mag_q <= y_q - x_q;
							neg_q <= sy;
						end
						state_q <= S_GCD;
					end
					ga_q <= '0;
					gb_q <= MAG_W'(prod);
				end
				S_GCD: begin
					// First entry seeds a = mag, or for a zero mag goes straight to the whole part; then one remainder per pass.
					if (ga_q == '0) begin
						if (mag_q == '0) begin
							neg_q <= 1'b0;
							ga_q <= MAG_W'(1);
							dreq.go <= 1'b1;
							dreq.num <= mag_q;
							dreq.den <= den_q;
							ret_q <= S_WHL;
							state_q <= S_WAIT;
						end else begin
							ga_q <= mag_q;
						end
					end else if (gb_q == '0) begin
						dreq.go <= 1'b1;
						dreq.num <= mag_q;
						dreq.den <= ga_q;
						ret_q <= S_RED1;
						state_q <= S_WAIT;
					end else begin
						dreq.go <= 1'b1;
						dreq.num <= ga_q;
						dreq.den <= gb_q;
						ret_q <= S_GCD;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (drsp.done) begin
						case (ret_q)
							S_GCD: begin
								ga_q <= gb_q;
								gb_q <= drsp.rem;
								state_q <= S_GCD;
							end
							S_RED1: begin
								mag_q <= drsp.quo;
								dreq.go <= 1'b1;
								dreq.num <= den_q;
								dreq.den <= ga_q;
								ret_q <= S_RED2;
							end
							S_RED2: begin
								den_q <= drsp.quo;
								dreq.go <= 1'b1;
								dreq.num <= mag_q;
								dreq.den <= drsp.quo;
								ret_q <= S_WHL;
							end
							default: begin
								state_q <= S_OUT;
								x_q <= drsp.quo;
								y_q <= drsp.rem;
							end
						endcase
					end
				end
				S_OUT: begin
					done <= 1'b1;
					state_q <= S_IDLE;
					if (den_q[MAG_W-1:FRAC_W] != '0 || x_q[MAG_W-1:WHOLE_W] != '0) begin
						error <= 1'b1;
						res_negative <= 1'b0;
						res_whole <= '0;
						res_num <= '0;
						res_den <= '0;
					end else begin
						error <= 1'b0;
						res_negative <= neg_q;
						res_whole <= x_q[WHOLE_W-1:0];
						res_num <= y_q[FRAC_W-1:0];
						res_den <= den_q[FRAC_W-1:0];
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A result never appears while the sequencer is busy.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");
	// An accepted item always leaves the idle state next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted item did not start");
	// A negative result is never flagged with an error.
	assert property (@(posedge clk) disable iff (!arst_n) (done && error) |-> !res_negative)
		else $error("error result carries a sign");
endmodule
`default_nettype wire
